### hdl/xcfr_pkg.sv
package xcfr_pkg;

	localparam logic [7:0] CHECK_SEED = 8'h55;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_CMD  = 3'd1,
		PH_LEN  = 3'd2,
		PH_PAY  = 3'd3,
		PH_CHK  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_BUSY    = 3'd0,
		ST_OK      = 3'd1,
		ST_LEN_ERR = 3'd2,
		ST_CHK_ERR = 3'd3,
		ST_TIMEOUT = 3'd4
	} status_t;

	typedef enum logic {
		REG_SOF_VALUE   = 1'b0,
		REG_MAX_PAYLOAD = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] sof_value;
		logic [7:0] max_payload;
	} cfg_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] frame_command;
		logic [7:0] frame_length;
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
	} result_t;

endpackage

### hdl/xcfr_cfg.sv
module xcfr_cfg import xcfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  reg_idx_t   cfg_addr,
	input  logic [7:0] cfg_wdata,
	output cfg_t       cfg
);

	logic [7:0] sof_value_q;
	logic [7:0] max_payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_value_q   <= 8'd0;
			max_payload_q <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SOF_VALUE:   sof_value_q   <= cfg_wdata;
				REG_MAX_PAYLOAD: max_payload_q <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	assign cfg.sof_value   = sof_value_q;
	assign cfg.max_payload = max_payload_q;

endmodule

### hdl/xcfr_ctrl.sv
module xcfr_ctrl import xcfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] rx_byte,
	input  logic       timed_out,
	input  cfg_t       cfg,
	output result_t    res
);

	phase_t     phase_q, phase_d;
	logic [7:0] check_q, check_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] len_q, len_d;
	logic [7:0] cnt_q, cnt_d;
	logic [7:0] check_x;
	logic [7:0] cnt_inc;

	assign check_x = check_q ^ rx_byte;
	assign cnt_inc = cnt_q + 8'd1;

	// next state
	always_comb begin
		phase_d = phase_q;
		check_d = check_q;
		cmd_d   = cmd_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		if (timed_out) begin
			phase_d = PH_HUNT;
			check_d = CHECK_SEED;
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == cfg.sof_value) begin
						check_d = CHECK_SEED ^ rx_byte;
						cmd_d   = 8'd0;
						len_d   = 8'd0;
						cnt_d   = 8'd0;
						phase_d = PH_CMD;
					end
				end
				PH_CMD: begin
					check_d = check_x;
					cmd_d   = rx_byte;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					check_d = check_x;
					len_d   = rx_byte;
					cnt_d   = 8'd0;
					if (rx_byte > cfg.max_payload) begin
						phase_d = PH_HUNT;
						check_d = CHECK_SEED;
					end else if (rx_byte == 8'd0) begin
						phase_d = PH_CHK;
					end else begin
						phase_d = PH_PAY;
					end
				end
				PH_PAY: begin
					check_d = check_x;
					cnt_d   = cnt_inc;
					if (cnt_inc == len_q)
						phase_d = PH_CHK;
				end
				PH_CHK: begin
					phase_d = PH_HUNT;
					check_d = CHECK_SEED;
				end
				default: begin
					phase_d = PH_HUNT;
					check_d = CHECK_SEED;
				end
			endcase
		end
	end

	// result for this request
	always_comb begin
		res.status        = ST_BUSY;
		res.frame_command = cmd_d;
		res.frame_length  = len_d;
		res.payload_valid = 1'b0;
		res.payload_byte  = 8'd0;
		res.payload_index = 8'd0;
		if (timed_out) begin
			res.status = ST_TIMEOUT;
		end else begin
			unique case (phase_q)
				PH_LEN: begin
					if (rx_byte > cfg.max_payload)
						res.status = ST_LEN_ERR;
				end
				PH_PAY: begin
					res.payload_valid = 1'b1;
					res.payload_byte  = rx_byte;
					res.payload_index = cnt_q;
				end
				PH_CHK: res.status = (check_x == 8'd0) ? ST_OK : ST_CHK_ERR;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			check_q <= CHECK_SEED;
			cmd_q   <= 8'd0;
			len_q   <= 8'd0;
			cnt_q   <= 8'd0;
		end else if (en) begin
			phase_q <= phase_d;
			check_q <= check_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end

	a_timeout_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		en && timed_out |=> phase_q == PH_HUNT && check_q == CHECK_SEED)
		else $error("timeout did not return to hunting");

	a_payload_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAY |-> cnt_q < len_q)
		else $error("payload count ran past frame length");

	a_check_seed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HUNT |-> check_q == CHECK_SEED)
		else $error("checksum not reseeded while hunting");

	a_final_status_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		en && (res.status == ST_OK || res.status == ST_CHK_ERR || res.status == ST_LEN_ERR)
		|=> phase_q == PH_HUNT)
		else $error("final status without returning to hunting");

endmodule

### hdl/xor_checked_frame_receiver_core.sv
// Framed byte receiver: each input request is one byte (s_tdata) or, with
// s_tuser high, a receive timeout event. The block hunts for the start-of-frame
// byte set in register 0, then takes a command byte and a length byte; a length
// above register 1 ends the frame with a length error. Payload bytes come out
// one per request with their index, and the check byte must make the XOR of
// 0x55 and every frame byte, start byte through check byte, zero. Every input
// request yields exactly one output request carrying the status and held
// command/length. Throughput is one request per clock while the output is not
// stalled; each request passes through the input register and then the result
// register, with the frame state updated as it moves between them.
module xor_checked_frame_receiver_core import xcfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        s_tuser,   // timed_out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // frame_command, frame_length, payload_byte, payload_index
	output logic [3:0]  m_tuser,   // status[2:0], payload_valid
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	cfg_t       cfg;
	result_t    res;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       timed_out_s1;
	logic       advance;
	logic       out_valid_q;
	result_t    out_q;

	xcfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (reg_idx_t'(cfg_addr)),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage 1 moves into the result register when that one is free or taken
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_byte_s1   <= s_tdata;
			timed_out_s1 <= s_tuser;
		end
	end

	xcfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.rx_byte   (rx_byte_s1),
		.timed_out (timed_out_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.payload_index, out_q.payload_byte,
	                   out_q.frame_length, out_q.frame_command};
	assign m_tuser  = {out_q.payload_valid, out_q.status};

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !advance)
		else $error("result register overwritten while stalled");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage dropped a pending request");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.payload_valid |-> out_q.payload_byte == 8'd0
		&& out_q.payload_index == 8'd0)
		else $error("payload fields set without payload");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top import xcfr_pkg::*;;

	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       timed_out;
	} rx_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // rx_byte
	logic        s_tuser = 1'b0; // timed_out
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // frame_command, frame_length, payload_byte, payload_index
	logic [3:0]  m_tuser;        // status[2:0], payload_valid
	logic        cfg_we = 1'b0;
	logic        cfg_addr = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	xor_checked_frame_receiver_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	rx_item_t rx_item_q[$];
	rx_item_t next_item;
	result_t  frame_exp_q[$];
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       pushed_cnt = 0;
	int       err_cnt = 0;
	int       stall_cnt = 0;

	// receiver state as the block should hold it
	phase_t     rx_phase = PH_HUNT;
	logic [7:0] rx_check = CHECK_SEED;
	logic [7:0] cmd_held = '0;
	logic [7:0] len_held = '0;
	logic [7:0] pay_count = '0;
	logic [7:0] cfg_sof = 8'h00;
	logic [7:0] cfg_max = 8'hFF;

	function automatic result_t rx_frame_step(logic [7:0] b, logic tmo);
		result_t r;
		r = '0;
		r.status = ST_BUSY;
		if (tmo) begin
			r.status = ST_TIMEOUT;
			rx_phase = PH_HUNT;
			rx_check = CHECK_SEED;
		end else begin
			case (rx_phase)
				PH_HUNT: begin
					if (b == cfg_sof) begin
						rx_check = CHECK_SEED ^ b;
						cmd_held = '0;
						len_held = '0;
						pay_count = '0;
						rx_phase = PH_CMD;
					end
				end
				PH_CMD: begin
					rx_check ^= b;
					cmd_held = b;
					rx_phase = PH_LEN;
				end
				PH_LEN: begin
					rx_check ^= b;
					len_held = b;
					pay_count = '0;
					if (b > cfg_max) begin
						r.status = ST_LEN_ERR;
						rx_phase = PH_HUNT;
						rx_check = CHECK_SEED;
					end else if (b == 8'h00) begin
						rx_phase = PH_CHK;
					end else begin
						rx_phase = PH_PAY;
					end
				end
				PH_PAY: begin
					rx_check ^= b;
					r.payload_valid = 1'b1;
					r.payload_byte = b;
					r.payload_index = pay_count;
					pay_count = pay_count + 8'd1;
					if (pay_count == len_held)
						rx_phase = PH_CHK;
				end
				PH_CHK: begin
					rx_check ^= b;
					if (rx_check == 8'h00)
						r.status = ST_OK;
					else
						r.status = ST_CHK_ERR;
					rx_phase = PH_HUNT;
					rx_check = CHECK_SEED;
				end
				default: begin
					rx_phase = PH_HUNT;
					rx_check = CHECK_SEED;
				end
			endcase
		end
		r.frame_command = cmd_held;
		r.frame_length = len_held;
		return r;
	endfunction

	// input side: one request per accepted byte or timeout event
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				frame_exp_q.push_back(rx_frame_step(s_tdata, s_tuser));
			if (!s_tvalid || s_tready) begin
				if (rx_item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_item = rx_item_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_item.rx_byte;
					s_tuser <= next_item.timed_out;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			err_cnt++;
		end
	endtask

	// output side
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (frame_exp_q.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, got tdata %0h tuser %0h",
						$time, m_tdata, m_tuser);
					err_cnt++;
				end else begin
					want = frame_exp_q.pop_front();
					check_field("status", 8'(want.status), 8'(m_tuser[2:0]));
					check_field("payload_valid", 8'(want.payload_valid), 8'(m_tuser[3]));
					check_field("frame_command", want.frame_command, m_tdata[7:0]);
					check_field("frame_length", want.frame_length, m_tdata[15:8]);
					check_field("payload_byte", want.payload_byte, m_tdata[23:16]);
					check_field("payload_index", want.payload_index, m_tdata[31:24]);
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end else begin
			stall_cnt <= 0;
		end
	end

	task automatic push_item(logic [7:0] rx, logic tmo);
		rx_item_q.push_back('{rx_byte: rx, timed_out: tmo});
		pushed_cnt++;
	endtask

	// sof to check byte, or to len byte if over max; a timeout at index tmo_at ends it
	task automatic push_frame(logic [7:0] cmd, logic [7:0] len, bit bad, int tmo_at);
		logic [7:0] seq[$];
		logic [7:0] sum;
		seq.push_back(cfg_sof);
		seq.push_back(cmd);
		seq.push_back(len);
		if (len <= cfg_max) begin
			for (int i = 0; i < int'(len); i++)
				seq.push_back(8'($urandom_range(0, 255)));
			sum = CHECK_SEED;
			foreach (seq[i])
				sum ^= seq[i];
			if (bad)
				sum ^= 8'(1 << $urandom_range(0, 7));
			seq.push_back(sum);
		end
		foreach (seq[i]) begin
			if (i == tmo_at) begin
				push_item(8'($urandom_range(0, 255)), 1'b1);
				return;
			end
			push_item(seq[i], 1'b0);
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (rx_item_q.size() != 0 || s_tvalid || frame_exp_q.size() != 0);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SOF_VALUE)
			cfg_sof = val;
		else
			cfg_max = val;
	endtask

	task automatic random_traffic(int n);
		int start;
		int r;
		logic [7:0] len;
		bit paused;
		start = pushed_cnt;
		paused = 0;
		while (pushed_cnt - start < n) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 15) == 0));
			r = $urandom_range(0, 19);
			if (r == 0)
				len = 8'($urandom_range(0, 255));
			else if (r == 1)
				len = (cfg_max == 8'hFF) ? cfg_max : cfg_max + 8'd1;
			else if (r == 2)
				len = (cfg_max > 8'd12) ? 8'($urandom_range(0, 12)) : cfg_max;
			else
				len = 8'($urandom_range(0, (cfg_max < 8'd6) ? int'(cfg_max) : 6));
			push_frame(8'($urandom_range(0, 255)), len, $urandom_range(0, 4) == 0,
				($urandom_range(0, 9) == 0) ? $urandom_range(0, int'(len) + 3) : -1);
			// hold the sender off until the block has answered everything
			if (!paused && pushed_cnt - start >= n / 2) begin
				drain();
				paused = 1;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset config: sof 0, max 255
		push_item(8'h3C, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h00, 1'b1);
		push_frame(8'hFF, 8'd2, 0, -1);
		push_item(8'h12, 1'b0);
		push_frame(8'h00, 8'd0, 1, -1);
		push_frame(8'h81, 8'd3, 0, 4);
		push_frame(8'h42, 8'd1, 0, 1);
		drain();
		write_reg(REG_SOF_VALUE, 8'hFF);
		write_reg(REG_MAX_PAYLOAD, 8'h00);
		push_frame(8'h5A, 8'd1, 0, -1);
		push_item(8'h00, 1'b0);
		push_frame(8'hA5, 8'd0, 0, -1);
		drain();

		send_idle_pct = 32;
		recv_idle_pct = 82;
		write_reg(REG_SOF_VALUE, 8'($urandom_range(0, 255)));
		write_reg(REG_MAX_PAYLOAD, 8'($urandom_range(1, 40)));
		random_traffic(220);
		drain();

		send_idle_pct = 82;
		recv_idle_pct = 32;
		write_reg(REG_SOF_VALUE, 8'h00);
		write_reg(REG_MAX_PAYLOAD, 8'($urandom_range(0, 255)));
		random_traffic(220);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_SOF_VALUE, 8'($urandom_range(0, 255)));
		write_reg(REG_MAX_PAYLOAD, 8'hFF);
		push_frame(8'($urandom_range(0, 255)), 8'hFF, 0, -1);
		random_traffic(220);
		drain();

		repeat (10) @(posedge clk);
		if (err_cnt == 0 && frame_exp_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			if (frame_exp_q.size() != 0)
				$display("%0t ns: %0d results missing, expected more, got none",
					$time, frame_exp_q.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
